FILE: rtl/fbsu_pkg.sv
// Shared types, constants and constant functions for the block score unit.
`default_nettype none
package fbsu_pkg;

    localparam int NUM_CONSTRAINTS = 4;
    localparam int ACTIVE_MAX = (NUM_CONSTRAINTS < 4) ? NUM_CONSTRAINTS : 4;
    localparam int IDX_W = (ACTIVE_MAX > 1) ? $clog2(ACTIVE_MAX) : 1;

    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_CAP0 = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAP1 = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAP2 = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CAP3 = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAMMA = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TAU = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_USED = 4'd7;

    localparam logic [14:0] ONE_P1_Q12 = 15'd4506;
    localparam logic [60:0] BAL_CAP = 61'h1000_0000_0000_0000;
    localparam logic [39:0] LOAD_MAX = 40'hFF_FFFF_FFFF;

    typedef enum logic [1:0] {
        OP_SCORE = 2'b01,
        OP_ADD   = 2'b10
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [31:0]        edge_weight_to_block;
        logic [31:0]        node_degree;
        logic [15:0]        neighbor_count;
        logic [15:0]        neighbor_rep_in_block;
        logic [10:0]        repl_block_count;
        logic               block_in_rep_set;
        logic [3:0][15:0]   weight;
    } item_t;

    typedef struct packed {
        logic [3:0][31:0]   capacity;
        logic [13:0]        gamma_q4_12;
        logic [15:0]        tau_q8_8;
        logic [10:0]        block_count;
        logic [2:0]         constraints_used;
    } cfg_t;

    typedef struct packed {
        logic [31:0]        score;
        logic [31:0]        max_load_ratio;
        logic               saturated;
    } res_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        logic [63:0] vv;
        r = 64'd0;
        b = 64'h4000_0000_0000_0000;
        vv = v;
        while (b > vv) b = b >> 2;
        while (b != 64'd0)
        begin
            if (vv >= r + b)
            begin
                vv = vv - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // 2^(2^-i) for i = 1..16 in Q1.31, entry i-1 at bits [(i-1)*32 +: 32]
    function automatic logic [16*32-1:0] exp2_roots();
        logic [63:0] c;
        logic [16*32-1:0] res;
        c = 64'h1_0000_0000;
        res = '0;
        for (int i = 0; i < 16; i++)
        begin
            c = isqrt64(c << 31);
            res[i*32 +: 32] = c[31:0];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/fennel_block_score_unit_top.sv
// Top level: configuration registers, front queue, score engine and result register.
`default_nettype none
// Scores one partition block for streaming graph partitioning and keeps its
// per-constraint loads. Requests enter through a two-entry queue; one engine
// serves them one at a time. An add updates the loads and then runs the ratio
// search for each active constraint on one shared bit-serial divider; a score
// runs the same ratio search, then normalization, log2 squaring and exp2
// products, and two more divisions when the node degree is nonzero. The result
// register lets the next request start while a result waits to be popped.
module fennel_block_score_unit_top
    import fbsu_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                   push,
    output logic                        full,
    input  wire logic                   req_type,
    input  wire logic [31:0]            edge_weight_to_block,
    input  wire logic [31:0]            node_degree,
    input  wire logic [15:0]            neighbor_count,
    input  wire logic [15:0]            neighbor_rep_in_block,
    input  wire logic [10:0]            repl_block_count,
    input  wire logic                   block_in_rep_set,
    input  wire logic [15:0]            weight_0,
    input  wire logic [15:0]            weight_1,
    input  wire logic [15:0]            weight_2,
    input  wire logic [15:0]            weight_3,
    output logic                        empty,
    input  wire logic                   pop,
    output logic signed [31:0]          score,
    output logic [31:0]                 max_load_ratio,
    output logic                        saturated
);

    cfg_t   cfg_reg;
    logic   q_valid;
    item_t  q_item;
    logic   q_pop;
    logic   res_valid;
    res_t   res;
    logic   res_ready;
    logic   out_valid_reg;
    res_t   out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.capacity <= {4{32'd1}};
            cfg_reg.gamma_q4_12 <= 14'd6144;
            cfg_reg.tau_q8_8 <= 16'd256;
            cfg_reg.block_count <= 11'd2;
            cfg_reg.constraints_used <= 3'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CAP0:   cfg_reg.capacity[0] <= cfg_wdata;
                CFG_CAP1:   cfg_reg.capacity[1] <= cfg_wdata;
                CFG_CAP2:   cfg_reg.capacity[2] <= cfg_wdata;
                CFG_CAP3:   cfg_reg.capacity[3] <= cfg_wdata;
                CFG_GAMMA:  cfg_reg.gamma_q4_12 <= cfg_wdata[13:0];
                CFG_TAU:    cfg_reg.tau_q8_8 <= cfg_wdata[15:0];
                CFG_BLOCKS: cfg_reg.block_count <= cfg_wdata[10:0];
                CFG_USED:   cfg_reg.constraints_used <= cfg_wdata[2:0];
                default:    ;
            endcase
        end
    end

    fbsu_front u_front (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .push                  (push),
        .full                  (full),
        .req_type              (req_type),
        .edge_weight_to_block  (edge_weight_to_block),
        .node_degree           (node_degree),
        .neighbor_count        (neighbor_count),
        .neighbor_rep_in_block (neighbor_rep_in_block),
        .repl_block_count      (repl_block_count),
        .block_in_rep_set      (block_in_rep_set),
        .weight_0              (weight_0),
        .weight_1              (weight_1),
        .weight_2              (weight_2),
        .weight_3              (weight_3),
        .q_valid               (q_valid),
        .q_item                (q_item),
        .q_pop                 (q_pop)
    );

    fbsu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready)
    );

    assign res_ready = !out_valid_reg || pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_ready)
            out_valid_reg <= res_valid;
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
            out_reg <= res;
    end

    assign empty = !out_valid_reg;
    assign score = $signed(out_reg.score);
    assign max_load_ratio = out_reg.max_load_ratio;
    assign saturated = out_reg.saturated;

endmodule
`default_nettype wire

FILE: rtl/fbsu_front.sv
// Front end: accepts requests, classifies them and queues them for the engine.
`default_nettype none
module fbsu_front
    import fbsu_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    output logic               full,
    input  wire logic          req_type,
    input  wire logic [31:0]   edge_weight_to_block,
    input  wire logic [31:0]   node_degree,
    input  wire logic [15:0]   neighbor_count,
    input  wire logic [15:0]   neighbor_rep_in_block,
    input  wire logic [10:0]   repl_block_count,
    input  wire logic          block_in_rep_set,
    input  wire logic [15:0]   weight_0,
    input  wire logic [15:0]   weight_1,
    input  wire logic [15:0]   weight_2,
    input  wire logic [15:0]   weight_3,
    output logic               q_valid,
    output item_t              q_item,
    input  wire logic          q_pop
);

    item_t       mem_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  cnt_reg, cnt_next;
    item_t       in_item;
    logic        do_push, do_pop;

    always_comb
    begin
        in_item.op = req_type ? OP_ADD : OP_SCORE;
        in_item.edge_weight_to_block = edge_weight_to_block;
        in_item.node_degree = node_degree;
        in_item.neighbor_count = neighbor_count;
        in_item.neighbor_rep_in_block = neighbor_rep_in_block;
        in_item.repl_block_count = repl_block_count;
        in_item.block_in_rep_set = block_in_rep_set;
        in_item.weight = {weight_3, weight_2, weight_1, weight_0};
    end

    assign full = (cnt_reg == 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 2'd1;
        else if (!do_push && do_pop)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= in_item;
    end

endmodule
`default_nettype wire

FILE: rtl/fbsu_div.sv
// Shared restoring divider, one quotient bit per cycle, left-aligned dividend.
`default_nettype none
module fbsu_div
    import fbsu_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [63:0]   dividend,
    input  wire logic [32:0]   divisor,
    input  wire logic [6:0]    iters,
    output logic               done,
    output logic [63:0]        quotient
);

    logic [33:0] rem_reg;
    logic [63:0] num_reg;
    logic [63:0] q_reg;
    logic [32:0] dvs_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [33:0] rem2;
    logic        ge;

    assign rem2 = {rem_reg[32:0], num_reg[63]};
    assign ge = (rem2 >= {1'b0, dvs_reg});
    assign done = done_reg;
    assign quotient = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= 7'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= iters;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            num_reg <= dividend;
            q_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[62:0], 1'b0};
            rem_reg <= ge ? (rem2 - {1'b0, dvs_reg}) : rem2;
            q_reg <= {q_reg[62:0], ge};
        end
    end

endmodule
`default_nettype wire

FILE: rtl/fbsu_back.sv
// Back end: load update, ratio search, log2/exp2 balance term and score sequencer.
`default_nettype none
module fbsu_back
    import fbsu_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire cfg_t          cfg,
    input  wire logic          q_valid,
    input  wire item_t         q_item,
    output logic               q_pop,
    output logic               res_valid,
    output res_t               res,
    input  wire logic          res_ready
);

    typedef enum logic [17:0] {
        S_IDLE   = 18'h00001,
        S_RSEL   = 18'h00002,
        S_RDIV   = 18'h00004,
        S_BAL    = 18'h00008,
        S_NORM   = 18'h00010,
        S_SQ     = 18'h00020,
        S_SQ2    = 18'h00040,
        S_TMUL   = 18'h00080,
        S_EXP0   = 18'h00100,
        S_EMUL   = 18'h00200,
        S_EACC   = 18'h00400,
        S_ESH    = 18'h00800,
        S_TERMS  = 18'h01000,
        S_EDIV   = 18'h02000,
        S_PSTART = 18'h04000,
        S_PDIV   = 18'h08000,
        S_FIN    = 18'h10000,
        S_OUT    = 18'h20000
    } state_t;

    localparam logic [16*32-1:0] ROOTS = exp2_roots();

    state_t              state_reg, state_next;
    item_t               item_reg, item_next;
    logic [39:0]         load_reg [ACTIVE_MAX];
    logic [39:0]         load_next [ACTIVE_MAX];
    logic [2:0]          cidx_reg, cidx_next;
    logic [31:0]         m_reg, m_next;
    logic                sat_reg, sat_next;
    logic [31:0]         x_reg, x_next;
    logic [4:0]          msb_reg, msb_next;
    logic [15:0]         frac_reg, frac_next;
    logic [3:0]          it_reg, it_next;
    logic [63:0]         prod_reg, prod_next;
    logic signed [36:0]  tprod_reg, tprod_next;
    logic signed [8:0]   nexp_reg, nexp_next;
    logic [15:0]         f_reg, f_next;
    logic [31:0]         y_reg, y_next;
    logic [60:0]         bal_reg, bal_next;
    logic [47:0]         a_reg, a_next;
    logic [40:0]         r_reg, r_next;
    logic [32:0]         tp_reg, tp_next;
    res_t                res_reg, res_next;

    logic [2:0]          n_act;
    logic signed [14:0]  e_val;
    logic                div_start;
    logic [63:0]         div_dividend;
    logic [32:0]         div_divisor;
    logic [6:0]          div_iters;
    logic                div_done;
    logic [63:0]         div_q;

    logic [31:0]         cap_sel;
    logic [39:0]         ld_sel;
    logic [31:0]         ratio;
    logic [40:0]         ld_sum;
    logic signed [5:0]   msb_m16;
    logic signed [21:0]  l_val;
    logic [3:0]          fbit_idx;
    logic [31:0]         root_sel;
    logic signed [9:0]   sh;
    logic [5:0]          rsh;
    logic [63:0]         shl;
    logic [16:0]         pen;
    logic [16:0]         pen_b;
    logic signed [65:0]  sc;

    fbsu_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .iters    (div_iters),
        .done     (div_done),
        .quotient (div_q)
    );

    assign n_act = (cfg.constraints_used > 3'(ACTIVE_MAX)) ? 3'(ACTIVE_MAX)
                                                         : cfg.constraints_used;
    assign e_val = $signed({1'b0, cfg.gamma_q4_12}) - $signed(ONE_P1_Q12);
    assign cap_sel = cfg.capacity[cidx_reg[1:0]];
    assign ld_sel = load_reg[cidx_reg[IDX_W-1:0]];
    assign msb_m16 = $signed({1'b0, msb_reg}) - 6'sd16;
    assign l_val = {msb_m16, frac_reg};
    assign fbit_idx = 4'd15 - it_reg;
    assign root_sel = ROOTS[it_reg*32 +: 32];
    assign sh = 10'(nexp_reg) - 10'sd15;
    assign rsh = 6'(-sh);
    assign shl = {32'd0, y_reg} << sh[4:0];
    assign pen_b = (item_reg.repl_block_count > 11'(item_reg.block_in_rep_set)) ?
                   17'(item_reg.repl_block_count - 11'(item_reg.block_in_rep_set)) : 17'd0;
    assign pen = 17'(item_reg.neighbor_count > item_reg.neighbor_rep_in_block ?
                     item_reg.neighbor_count - item_reg.neighbor_rep_in_block : 16'd0)
                 + pen_b;

    assign q_pop = (state_reg == S_IDLE) && q_valid;
    assign res_valid = (state_reg == S_OUT);
    assign res = res_reg;

    always_comb
    begin
        state_next = state_reg;
        item_next = item_reg;
        load_next = load_reg;
        cidx_next = cidx_reg;
        m_next = m_reg;
        sat_next = sat_reg;
        x_next = x_reg;
        msb_next = msb_reg;
        frac_next = frac_reg;
        it_next = it_reg;
        prod_next = prod_reg;
        tprod_next = tprod_reg;
        nexp_next = nexp_reg;
        f_next = f_reg;
        y_next = y_reg;
        bal_next = bal_reg;
        a_next = a_reg;
        r_next = r_reg;
        tp_next = tp_reg;
        res_next = res_reg;
        div_start = 1'b0;
        div_dividend = '0;
        div_divisor = '0;
        div_iters = '0;
        ratio = '0;
        ld_sum = '0;
        sc = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    item_next = q_item;
                    sat_next = 1'b0;
                    m_next = '0;
                    cidx_next = '0;
                    if (q_item.op == OP_ADD)
                    begin
                        for (int i = 0; i < ACTIVE_MAX; i++)
                        begin
                            if (3'(i) < n_act)
                            begin
                                ld_sum = {1'b0, load_reg[i]} + 41'(q_item.weight[i]);
                                if (ld_sum[40])
                                begin
                                    load_next[i] = LOAD_MAX;
                                    sat_next = 1'b1;
                                end
                                else
                                begin
                                    load_next[i] = ld_sum[39:0];
                                end
                            end
                        end
                    end
                    state_next = S_RSEL;
                end
            end
            S_RSEL:
            begin
                if (cidx_reg >= n_act)
                begin
                    state_next = S_BAL;
                end
                else if (cap_sel == 32'd0)
                begin
                    if (ld_sel != 40'd0)
                    begin
                        m_next = 32'hFFFF_FFFF;
                        sat_next = 1'b1;
                    end
                    cidx_next = cidx_reg + 3'd1;
                end
                else
                begin
                    div_start = 1'b1;
                    div_dividend = {ld_sel, 24'd0};
                    div_divisor = {1'b0, cap_sel};
                    div_iters = 7'd56;
                    state_next = S_RDIV;
                end
            end
            S_RDIV:
            begin
                if (div_done)
                begin
                    if (div_q[63:32] != 32'd0)
                    begin
                        ratio = 32'hFFFF_FFFF;
                        sat_next = 1'b1;
                    end
                    else
                    begin
                        ratio = div_q[31:0];
                    end
                    if (ratio > m_reg)
                        m_next = ratio;
                    cidx_next = cidx_reg + 3'd1;
                    state_next = S_RSEL;
                end
            end
            S_BAL:
            begin
                if (item_reg.op == OP_ADD)
                begin
                    res_next.score = '0;
                    res_next.max_load_ratio = m_reg;
                    res_next.saturated = sat_reg;
                    state_next = S_OUT;
                end
                else if (e_val == 15'sd0)
                begin
                    bal_next = 61'd65536;
                    state_next = S_TERMS;
                end
                else if (m_reg == 32'd0)
                begin
                    bal_next = (e_val > 15'sd0) ? 61'd0 : BAL_CAP;
                    state_next = S_TERMS;
                end
                else
                begin
                    x_next = m_reg;
                    msb_next = 5'd31;
                    state_next = S_NORM;
                end
            end
            S_NORM:
            begin
                if (x_reg[31])
                begin
                    frac_next = '0;
                    it_next = '0;
                    state_next = S_SQ;
                end
                else
                begin
                    x_next = {x_reg[30:0], 1'b0};
                    msb_next = msb_reg - 5'd1;
                end
            end
            S_SQ:
            begin
                prod_next = 64'(x_reg) * 64'(x_reg);
                state_next = S_SQ2;
            end
            S_SQ2:
            begin
                if (prod_reg[63])
                begin
                    x_next = prod_reg[63:32];
                    frac_next = {frac_reg[14:0], 1'b1};
                end
                else
                begin
                    x_next = prod_reg[62:31];
                    frac_next = {frac_reg[14:0], 1'b0};
                end
                it_next = it_reg + 4'd1;
                state_next = (it_reg == 4'd15) ? S_TMUL : S_SQ;
            end
            S_TMUL:
            begin
                tprod_next = 37'(l_val) * 37'(e_val);
                state_next = S_EXP0;
            end
            S_EXP0:
            begin
                // floor divide by 4096, then split into integer and fraction
                nexp_next = tprod_reg[36:28];
                f_next = tprod_reg[27:12];
                y_next = 32'h8000_0000;
                it_next = '0;
                state_next = S_EMUL;
            end
            S_EMUL:
            begin
                prod_next = 64'(y_reg) * 64'(root_sel);
                state_next = S_EACC;
            end
            S_EACC:
            begin
                if (f_reg[fbit_idx])
                    y_next = prod_reg[62:31];
                it_next = it_reg + 4'd1;
                state_next = (it_reg == 4'd15) ? S_ESH : S_EMUL;
            end
            S_ESH:
            begin
                if (sh >= 10'sd32)
                    bal_next = BAL_CAP;
                else if (sh >= 10'sd0)
                    bal_next = (shl > 64'(BAL_CAP)) ? BAL_CAP : shl[60:0];
                else if (sh <= -10'sd64)
                    bal_next = '0;
                else
                    bal_next = 61'({32'd0, y_reg} >> rsh);
                state_next = S_TERMS;
            end
            S_TERMS:
            begin
                a_next = '0;
                r_next = '0;
                tp_next = 33'(cfg.tau_q8_8) * 33'(pen);
                if (item_reg.node_degree == 32'd0)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    div_start = 1'b1;
                    div_dividend = {item_reg.edge_weight_to_block, 32'd0};
                    div_divisor = {1'b0, item_reg.node_degree};
                    div_iters = 7'd48;
                    state_next = S_EDIV;
                end
            end
            S_EDIV:
            begin
                if (div_done)
                begin
                    a_next = div_q[47:0];
                    state_next = S_PSTART;
                end
            end
            S_PSTART:
            begin
                div_start = 1'b1;
                div_dividend = {tp_reg, 31'd0};
                div_divisor = 33'(item_reg.node_degree) + 33'(cfg.block_count);
                div_iters = 7'd41;
                state_next = S_PDIV;
            end
            S_PDIV:
            begin
                if (div_done)
                begin
                    r_next = div_q[40:0];
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                sc = $signed(66'(a_reg)) - $signed(66'(bal_reg)) - $signed(66'(r_reg));
                res_next.max_load_ratio = m_reg;
                res_next.saturated = sat_reg;
                if (sc > 66'sh7FFF_FFFF)
                begin
                    res_next.score = 32'h7FFF_FFFF;
                    res_next.saturated = 1'b1;
                end
                else if (sc < -66'sh8000_0000)
                begin
                    res_next.score = 32'h8000_0000;
                    res_next.saturated = 1'b1;
                end
                else
                begin
                    res_next.score = sc[31:0];
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (res_ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            for (int i = 0; i < ACTIVE_MAX; i++)
                load_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            load_reg <= load_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        cidx_reg <= cidx_next;
        m_reg <= m_next;
        sat_reg <= sat_next;
        x_reg <= x_next;
        msb_reg <= msb_next;
        frac_reg <= frac_next;
        it_reg <= it_next;
        prod_reg <= prod_next;
        tprod_reg <= tprod_next;
        nexp_reg <= nexp_next;
        f_reg <= f_next;
        y_reg <= y_next;
        bal_reg <= bal_next;
        a_reg <= a_next;
        r_reg <= r_next;
        tp_reg <= tp_next;
        res_reg <= res_next;
    end

endmodule
`default_nettype wire

FILE: bench/tb_fennel_block_score_unit_top.sv
// Self-checking testbench for the block score unit: directed and random requests.
`timescale 1ns / 100ps
`default_nettype none
module tb_fennel_block_score_unit_top;
    import fbsu_pkg::*;

    localparam logic REQ_SCORE = 1'b0;
    localparam logic REQ_ADD = 1'b1;
    localparam int STALL_LIMIT = 20000;
    localparam logic [63:0] RATIO_MAX = 64'hFFFF_FFFF;
    localparam logic [63:0] BALANCE_CAP = 64'h1000_0000_0000_0000;

    typedef struct {
        logic signed [31:0] score;
        logic [31:0] ratio;
        logic sat;
    } score_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_CAP0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic push = 1'b0;
    logic full;
    logic req_type = REQ_SCORE;
    logic [31:0] edge_weight_to_block = '0;
    logic [31:0] node_degree = '0;
    logic [15:0] neighbor_count = '0;
    logic [15:0] neighbor_rep_in_block = '0;
    logic [10:0] repl_block_count = '0;
    logic block_in_rep_set = 1'b0;
    logic [15:0] weight_0 = '0;
    logic [15:0] weight_1 = '0;
    logic [15:0] weight_2 = '0;
    logic [15:0] weight_3 = '0;
    logic empty;
    logic pop = 1'b0;
    logic signed [31:0] score;
    logic [31:0] max_load_ratio;
    logic saturated;

    // shadow of the block's configuration and loads
    logic [31:0] cap_m [4];
    logic [13:0] gamma_m;
    logic [15:0] tau_m;
    logic [10:0] blocks_m;
    logic [2:0] used_m;
    logic [39:0] load_m [4];
    logic [63:0] root_tab [17];

    score_result_t expected_scores [$];
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatches = 0;
    int items_sent = 0;
    int results_seen = 0;
    int quiet_cycles = 0;

    fennel_block_score_unit_top i_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .push(push), .full(full),
        .req_type(req_type), .edge_weight_to_block(edge_weight_to_block),
        .node_degree(node_degree), .neighbor_count(neighbor_count),
        .neighbor_rep_in_block(neighbor_rep_in_block), .repl_block_count(repl_block_count),
        .block_in_rep_set(block_in_rep_set),
        .weight_0(weight_0), .weight_1(weight_1), .weight_2(weight_2), .weight_3(weight_3),
        .empty(empty), .pop(pop),
        .score(score), .max_load_ratio(max_load_ratio), .saturated(saturated)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] cand;
        r = '0;
        for (int b = 31; b >= 0; b--)
        begin
            cand = r | (64'd1 << b);
            if (cand * cand <= v)
                r = cand;
        end
        return r;
    endfunction

    function automatic int active_constraints();
        return (used_m > 3'd4) ? 4 : int'(used_m);
    endfunction

    function automatic logic [31:0] largest_ratio(inout logic sat);
        logic [63:0] m;
        logic [63:0] r;
        m = '0;
        for (int i = 0; i < active_constraints(); i++)
        begin
            if (cap_m[i] == 0)
            begin
                if (load_m[i] == 0)
                    continue;
                r = RATIO_MAX;
                sat = 1'b1;
            end
            else
            begin
                r = ({24'd0, load_m[i]} << 16) / cap_m[i];
                if (r > RATIO_MAX)
                begin
                    r = RATIO_MAX;
                    sat = 1'b1;
                end
            end
            if (r > m)
                m = r;
        end
        return m[31:0];
    endfunction

    function automatic longint log2_fixed(input logic [31:0] m);
        int msb;
        logic [63:0] x;
        longint frac;
        msb = 31;
        frac = 0;
        while (m[msb] == 1'b0)
            msb--;
        x = {32'd0, m} << (31 - msb);
        for (int i = 0; i < 16; i++)
        begin
            x = (x * x) >> 31;
            frac = frac << 1;
            if (x >= 64'h1_0000_0000)
            begin
                frac = frac | 1;
                x = x >> 1;
            end
        end
        return longint'(msb - 16) * 65536 + frac;
    endfunction

    function automatic logic [63:0] exp2_fixed(input longint t);
        longint n;
        longint sh;
        longint f;
        logic [63:0] y;
        logic [63:0] v;
        n = t >>> 16;
        f = t - n * 65536;
        y = 64'h8000_0000;
        for (int i = 1; i <= 16; i++)
            if (f[16-i])
                y = (y * root_tab[i]) >> 31;
        sh = n - 15;
        if (sh >= 32)
            return BALANCE_CAP;
        if (sh >= 0)
            v = y << sh;
        else if (-sh >= 64)
            v = '0;
        else
            v = y >> (-sh);
        return (v > BALANCE_CAP) ? BALANCE_CAP : v;
    endfunction

    // Computes the result of one accepted request and, for an add, advances the loads.
    function automatic score_result_t predict_block_score();
        score_result_t res;
        logic sat;
        logic [31:0] m;
        logic [63:0] bal;
        logic [63:0] s;
        logic [63:0] pen;
        logic [63:0] edge_q;
        logic [63:0] pen_q;
        logic [15:0] w [4];
        longint e;
        longint total;
        sat = 1'b0;
        w[0] = weight_0;
        w[1] = weight_1;
        w[2] = weight_2;
        w[3] = weight_3;
        if (req_type == REQ_ADD)
        begin
            for (int i = 0; i < active_constraints(); i++)
            begin
                s = {24'd0, load_m[i]} + 64'(w[i]);
                if (s > {24'd0, LOAD_MAX})
                begin
                    s = {24'd0, LOAD_MAX};
                    sat = 1'b1;
                end
                load_m[i] = s[39:0];
            end
            res.ratio = largest_ratio(sat);
            res.score = '0;
            res.sat = sat;
            return res;
        end
        m = largest_ratio(sat);
        e = longint'(gamma_m) - longint'(ONE_P1_Q12);
        if (e == 0)
            bal = 64'd65536;
        else if (m == 0)
            bal = (e > 0) ? 64'd0 : BALANCE_CAP;
        else
            bal = exp2_fixed((log2_fixed(m) * e) >>> 12);
        if (node_degree == 0)
            total = -longint'(bal);
        else
        begin
            pen = ((neighbor_count > neighbor_rep_in_block) ?
                   64'(neighbor_count - neighbor_rep_in_block) : 64'd0) +
                  ((repl_block_count > block_in_rep_set) ?
                   64'(repl_block_count - block_in_rep_set) : 64'd0);
            edge_q = ({32'd0, edge_weight_to_block} << 16) / node_degree;
            pen_q = (64'(tau_m) * pen * 256) / (64'(node_degree) + 64'(blocks_m));
            total = longint'(edge_q) - longint'(bal) - longint'(pen_q);
        end
        if (total > 64'sh7FFF_FFFF)
        begin
            total = 64'sh7FFF_FFFF;
            sat = 1'b1;
        end
        if (total < -64'sh8000_0000)
        begin
            total = -64'sh8000_0000;
            sat = 1'b1;
        end
        res.score = total[31:0];
        res.ratio = m;
        res.sat = sat;
        return res;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_CAP0: cap_m[0] = val;
            CFG_CAP1: cap_m[1] = val;
            CFG_CAP2: cap_m[2] = val;
            CFG_CAP3: cap_m[3] = val;
            CFG_GAMMA: gamma_m = val[13:0];
            CFG_TAU: tau_m = val[15:0];
            CFG_BLOCKS: blocks_m = val[10:0];
            CFG_USED: used_m = val[2:0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (expected_scores.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic send_request(input logic kind, input logic [31:0] ew, input logic [31:0] deg,
                                input logic [15:0] dc, input logic [15:0] nr,
                                input logic [10:0] pre, input logic flag,
                                input logic [63:0] wts);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        req_type <= kind;
        edge_weight_to_block <= ew;
        node_degree <= deg;
        neighbor_count <= dc;
        neighbor_rep_in_block <= nr;
        repl_block_count <= pre;
        block_in_rep_set <= flag;
        {weight_3, weight_2, weight_1, weight_0} <= wts;
        @(posedge clk);
        while (full)
            @(posedge clk);
        expected_scores.push_back(predict_block_score());
        items_sent++;
    endtask

    function automatic logic [31:0] wide_rand();
        return $urandom >> $urandom_range(31);
    endfunction

    task automatic random_request(input int add_pct);
        send_request($urandom_range(99) < add_pct, wide_rand(),
                     ($urandom_range(9) == 0) ? 32'd0 : wide_rand(),
                     16'($urandom),
                     16'(($urandom_range(3) == 0) ? $urandom : $urandom_range(64)),
                     11'($urandom_range(1024)), 1'($urandom_range(1)),
                     {$urandom, $urandom} >> (16 * $urandom_range(3)));
    endtask

    task automatic test_defaults();
        send_request(REQ_SCORE, 32'd100, 32'd10, 16'd5, 16'd2, 11'd3, 1'b1, '0);
        send_request(REQ_ADD, '0, '0, '0, '0, '0, 1'b0, {4{16'd1}});
        send_request(REQ_SCORE, 32'hFFFF_FFFF, 32'd1, 16'hFFFF, 16'd0, 11'd1024, 1'b0, '0);
        send_request(REQ_SCORE, 32'd7, 32'd0, 16'd9, 16'd1, 11'd4, 1'b1, '0);
        wait_drained();
    endtask

    task automatic test_special_cases();
        // exponent exactly zero, then negative with no active constraints
        write_reg(CFG_GAMMA, 32'(ONE_P1_Q12));
        send_request(REQ_SCORE, 32'd0, 32'd0, '0, '0, '0, 1'b0, '0);
        wait_drained();
        write_reg(CFG_GAMMA, 32'd4096);
        write_reg(CFG_USED, 32'd0);
        send_request(REQ_SCORE, 32'd5, 32'd3, 16'd1, 16'd9, 11'd0, 1'b1, '0);
        send_request(REQ_ADD, '0, '0, '0, '0, '0, 1'b0, {4{16'hFFFF}});
        wait_drained();
        // zero capacity, all constraints, zero blocks, widest tau
        write_reg(CFG_USED, 32'd7);
        write_reg(CFG_CAP2, 32'd0);
        write_reg(CFG_CAP3, 32'hFFFF_FFFF);
        write_reg(CFG_BLOCKS, 32'd0);
        write_reg(CFG_TAU, 32'hFFFF);
        write_reg(CFG_GAMMA, 32'd16383);
        send_request(REQ_SCORE, 32'd1, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 11'd1, 1'b1, '0);
        send_request(REQ_ADD, '0, '0, '0, '0, '0, 1'b0, {16'h8000, 16'd3, 16'hFFFF, 16'd0});
        send_request(REQ_SCORE, 32'h8000_0000, 32'd1, 16'd0, 16'd0, 11'd2047, 1'b0, '0);
        send_request(REQ_SCORE, 32'd0, 32'd2, 16'd0, 16'd0, 11'd0, 1'b0, '0);
        wait_drained();
        write_reg(CFG_BLOCKS, 32'd1024);
        write_reg(CFG_TAU, 32'd0);
        write_reg(CFG_USED, 32'd4);
        write_reg(CFG_CAP0, 32'd1);
        write_reg(CFG_CAP1, 32'd1);
        write_reg(CFG_CAP2, 32'd1);
        send_request(REQ_SCORE, 32'd3, 32'd9, 16'd4, 16'd4, 11'd0, 1'b0, '0);
        send_request(REQ_ADD, '0, '0, '0, '0, '0, 1'b0, {4{16'h5A5A}});
        send_request(REQ_SCORE, 32'd3, 32'd9, 16'd4, 16'd4, 11'd0, 1'b0, '0);
        wait_drained();
    endtask

    task automatic test_random_phase(input int idle, input int stall, input int count);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        for (int i = CFG_CAP0; i <= CFG_CAP3; i++)
            write_reg(i[CFG_IDX_W-1:0], wide_rand() | 32'd1);
        write_reg(CFG_GAMMA, $urandom_range(4096, 16383));
        write_reg(CFG_TAU, $urandom_range(65535));
        write_reg(CFG_BLOCKS, $urandom_range(1, 1024));
        write_reg(CFG_USED, $urandom_range(1, 4));
        for (int n = 0; n < count; n++)
            random_request(40);
        wait_drained();
    endtask

    // result checker
    always @(posedge clk)
    begin
        score_result_t exp_r;
        if (rst_n && pop && !empty)
        begin
            results_seen++;
            if (expected_scores.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction: score %0d ratio %h", score,
                             max_load_ratio);
            end
            else
            begin
                exp_r = expected_scores.pop_front();
                if (score !== exp_r.score || max_load_ratio !== exp_r.ratio ||
                    saturated !== exp_r.sat)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch #%0d: exp score %0d ratio %h sat %b, got %0d %h %b",
                                 results_seen, exp_r.score, exp_r.ratio, exp_r.sat,
                                 score, max_load_ratio, saturated);
                end
            end
        end
    end

    always @(posedge clk)
        pop <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < 4; i++)
        begin
            cap_m[i] = 32'd1;
            load_m[i] = '0;
        end
        gamma_m = 14'd6144;
        tau_m = 16'd256;
        blocks_m = 11'd2;
        used_m = 3'd1;
        root_tab[0] = 64'h1_0000_0000;
        for (int i = 1; i <= 16; i++)
            root_tab[i] = floor_sqrt(root_tab[i-1] << 31);
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        test_defaults();
        test_special_cases();
        test_random_phase(0, 0, 100);
        test_random_phase(65, 0, 100);
        test_random_phase(0, 65, 100);
        test_random_phase(29, 29, 100);
        wait_drained();
        repeat (500) @(posedge clk);
        if (expected_scores.size() != 0)
            mismatches++;
        $display("covered %0d requests, %0d results checked, %0d mismatches", items_sent,
                 results_seen, mismatches);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
`default_nettype wire
